[hdl/sis_pkg.sv]
// ----------------------------------------------------------------------------
// sis_pkg
// Shared constants and types for the sorted identifier set: capacity, widths,
// operation and status codes, and the control and status bundles of a cell.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

    // number of cells in the chain (2 to 127)
    localparam int CAPACITY = 64;

    // width of the key count, able to hold CAPACITY itself
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int KEY_W   = 64;
    localparam int SCOUNT_W = 7;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // status codes
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // control into one cell
    typedef struct packed {
        logic occupied;   // cell index below the key count
        logic shift_en;   // an accepted insert updates the chain this cycle
    } cell_ctl_t;

    // status out of one cell
    typedef struct packed {
        logic less;       // occupied and stored key below the probe key
        logic match;      // occupied and stored key equal to the probe key
    } cell_stat_t;

endpackage

`default_nettype wire

[hdl/sis_cell.sv]
// ----------------------------------------------------------------------------
// sis_cell
// One position of the sorted chain. Compares its key with the probe key and,
// on an insert, keeps its key, takes the probe key, or takes its lower
// neighbour's key so the larger entries move up by one.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_cell (
    input  wire logic              clk,
    input  wire sis_pkg::cell_ctl_t ctl,
    input  wire sis_pkg::key_t     probe,
    input  wire sis_pkg::key_t     prev_key,
    input  wire logic              prev_less,
    output sis_pkg::key_t          key_q,
    output sis_pkg::cell_stat_t    stat
);

    sis_pkg::key_t key_reg;
    sis_pkg::key_t key_next;

    // compare against the probe key
    always_comb
    begin
        stat.less  = ctl.occupied && (key_reg < probe);
        stat.match = ctl.occupied && (key_reg == probe);
    end

    // select the new content of this position
    always_comb
    begin
        key_next = key_reg;
        if (ctl.shift_en && !stat.less)
        begin
            if (prev_less)
                key_next = probe;
            else
                key_next = prev_key;
        end
    end

    // key storage, no reset needed
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q = key_reg;

endmodule

`default_nettype wire

[hdl/sorted_id_set.sv]
// ----------------------------------------------------------------------------
// sorted_id_set
// Ascending sorted store of 64-bit identifiers built as a chain of cells.
// Inserts place the key at its lower-bound position and shift larger entries
// up; queries report whether the key is held.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload
//  -------   --------------   ----------------------------------
//  command   start / busy     operation, key
//  result    done (strobe)    status, found, stored_count
//
// An item is taken on a clock edge with start high and busy low; busy is
// always low, so an item may be given every cycle.
// The item is registered, then every cell compares and shifts in the next
// cycle; the result strobe and payload are registered as the cells shift.
// Reset clears the key count and the pipeline valids; keys need no reset.
// The receiver cannot stall, so nothing holds the pipeline back.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_id_set (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          operation,
    input  wire logic [sis_pkg::KEY_W-1:0]     key,
    output logic                               done,
    output logic                               status,
    output logic                               found,
    output logic [sis_pkg::SCOUNT_W-1:0]       stored_count
);

    localparam int N = sis_pkg::CAPACITY;

    // registered item
    logic          valid_reg;
    logic          op_reg;
    sis_pkg::key_t probe_reg;

    // key count
    sis_pkg::cnt_t count_reg;
    sis_pkg::cnt_t count_next;

    // result registers
    logic          done_reg;
    logic          status_reg;
    logic          found_reg;
    sis_pkg::cnt_t res_count_reg;

    // chain wiring
    sis_pkg::key_t      cell_key  [N];
    sis_pkg::cell_stat_t cell_stat [N];
    sis_pkg::cell_ctl_t  cell_ctl  [N];
    logic [N-1:0]       match_vec;

    logic full;
    logic do_insert;
    logic [31:0] res_count_wide;

    assign busy = 1'b0;

    // decode the registered item
    always_comb
    begin
        full      = (count_reg == sis_pkg::cnt_t'(N));
        do_insert = valid_reg && (op_reg == sis_pkg::OP_INSERT) && !full;
        count_next = count_reg;
        if (do_insert)
            count_next = count_reg + sis_pkg::cnt_t'(1);
    end

    // row of cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        assign cell_ctl[i].occupied = (sis_pkg::cnt_t'(i) < count_reg);
        assign cell_ctl[i].shift_en = do_insert;
        assign match_vec[i]         = cell_stat[i].match;

        if (i == 0)
        begin : g_first
            sis_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[i]),
                .probe     (probe_reg),
                .prev_key  (probe_reg),
                .prev_less (1'b1),
                .key_q     (cell_key[i]),
                .stat      (cell_stat[i])
            );
        end
        else
        begin : g_rest
            sis_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[i]),
                .probe     (probe_reg),
                .prev_key  (cell_key[i-1]),
                .prev_less (cell_stat[i-1].less),
                .key_q     (cell_key[i]),
                .stat      (cell_stat[i])
            );
        end
    end

    // input register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg    <= operation;
            probe_reg <= key;
        end
    end

    // count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= valid_reg;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            status_reg    <= (op_reg == sis_pkg::OP_INSERT && full) ?
                             sis_pkg::ST_FULL : sis_pkg::ST_DONE;
            found_reg     <= (op_reg == sis_pkg::OP_QUERY) && (|match_vec);
            res_count_reg <= count_next;
        end
    end

    assign res_count_wide = 32'(res_count_reg);

    assign done         = done_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign stored_count = res_count_wide[sis_pkg::SCOUNT_W-1:0];

endmodule

`default_nettype wire
